// ===== rtl/core/gcis_pkg.sv =====
// Package for the gear constraint impulse solver: transfer payload types,
// command and register codes, sequencer states and saturation helpers.
// No dependencies.
package gcis_pkg;

   // Multiplier operand width: 32-bit signed or 31-bit unsigned plus sign
   localparam int OPW = 33;

   // Command codes
   localparam logic [1:0] CMD_PRESOLVE = 2'd0;
   localparam logic [1:0] CMD_SOLVE    = 2'd1;
   localparam logic [1:0] CMD_APPLY    = 2'd2;

   // Register indexes
   localparam logic [1:0] REG_GEAR_RATIO     = 2'd0;
   localparam logic [1:0] REG_RATIO_INVERSE  = 2'd1;
   localparam logic [1:0] REG_PHASE_OFFSET   = 2'd2;
   localparam logic [1:0] REG_INV_TIMESTEP   = 2'd3;

   localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [31:0] angle_a;
      logic signed [31:0] angle_b;
      logic signed [31:0] omega_a;
      logic signed [31:0] omega_b;
      logic [30:0]        inv_inertia_a;
      logic [30:0]        inv_inertia_b;
   } req_type;

   typedef struct packed {
      logic signed [31:0] omega_a_out;
      logic signed [31:0] omega_b_out;
      logic signed [31:0] impulse_total;
   } rsp_type;

   // Sequencer states: presolve, solve and apply steps
   typedef enum logic [20:0] {
      ST_IDLE = 21'b1 << 0,
      ST_PS0  = 21'b1 << 1,
      ST_PS1  = 21'b1 << 2,
      ST_PS2  = 21'b1 << 3,
      ST_PS3  = 21'b1 << 4,
      ST_PS4  = 21'b1 << 5,
      ST_PS5  = 21'b1 << 6,
      ST_PS6  = 21'b1 << 7,
      ST_PS7  = 21'b1 << 8,
      ST_PS8  = 21'b1 << 9,
      ST_SV0  = 21'b1 << 10,
      ST_SV1  = 21'b1 << 11,
      ST_SV2  = 21'b1 << 12,
      ST_SV3  = 21'b1 << 13,
      ST_SV4  = 21'b1 << 14,
      ST_SV5  = 21'b1 << 15,
      ST_AP0  = 21'b1 << 16,
      ST_AP1  = 21'b1 << 17,
      ST_AP2  = 21'b1 << 18,
      ST_AP3  = 21'b1 << 19,
      ST_FIN  = 21'b1 << 20
   } state_type;

   // Sign-extend to the width of a three-term sum
   function automatic logic signed [33:0] sx34(input logic signed [31:0] v);
      return {{2{v[31]}}, v};
   endfunction

   // Clamp a 34-bit sum to the signed 32-bit range
   function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
         r = v[31:0];
      end else if (v[33]) begin
         r = S32_MIN;
      end else begin
         r = S32_MAX;
      end
      return r;
   endfunction

   // Multiplier operand from a signed 32-bit value
   function automatic logic signed [OPW-1:0] opnd_s(input logic signed [31:0] v);
      return {v[31], v};
   endfunction

   // Multiplier operand from an unsigned 31-bit value
   function automatic logic signed [OPW-1:0] opnd_u(input logic [30:0] v);
      return {2'b00, v};
   endfunction

endpackage

// ===== rtl/core/gear_constraint_impulse_solver.sv =====
// Gear constraint impulse solver: top level with sequencer, state and
// configuration registers. Uses gcis_pkg, gcis_mul and gcis_div.
//
// Usage:
//   Items enter on req_* (valid/stall) and one result leaves on rsp_* per
//   item. The csr_* port writes gear ratio, ratio inverse, phase offset and
//   inverse timestep; write it only while no item is in flight.
//   One item is worked at a time through one shared 33x33 multiplier,
//   which sets the step count. A presolve also waits on the bit-serial
//   divider for the effective mass, a quotient of 2*FRAC_BITS + 1 bits
//   (33 at Q16.16), except when the inverse mass sum is zero and no
//   divide runs.
//   Results sit in an output register; the next item is taken while a
//   result waits. A stalled receiver holds the finished item in its last
//   step until the output register frees.
//   Reset clears the stored impulse, effective mass and bias, loads the
//   register defaults (ratio 1.0, inverse 1.0, offset 0, 60 per second)
//   and empties the output register.
module gear_constraint_impulse_solver
   import gcis_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int QW = 2 * FRAC_BITS + 1;
   localparam logic [QW-1:0]          DIV_NUM   = {1'b1, {(QW - 1){1'b0}}};
   localparam logic signed [OPW-1:0]  BETA_OP   = OPW'(((2**FRAC_BITS) * 2 + 5) / 10);
   localparam logic signed [31:0]     ONE_Q     = 32'(2**FRAC_BITS);
   localparam logic [30:0]            ITS_RESET = 31'(60 * (2**FRAC_BITS));

   state_type          state_ff, state_in;
   req_type            in_ff, in_in;
   logic signed [31:0] t_ff, t_in;
   logic signed [31:0] u_ff, u_in;
   logic signed [31:0] acc_ff, acc_in;
   logic signed [31:0] emass_ff, emass_in;
   logic signed [31:0] bias_ff, bias_in;
   logic signed [31:0] oa_ff, oa_in;
   logic signed [31:0] ob_ff, ob_in;
   logic signed [31:0] tot_ff, tot_in;
   logic               zero_ff, zero_in;
   logic               neg_ff, neg_in;
   logic signed [31:0] ratio_ff, ratio_in;
   logic signed [31:0] rinv_ff, rinv_in;
   logic signed [31:0] phase_ff, phase_in;
   logic [30:0]        its_ff, its_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic signed [OPW-1:0] op_a, op_b;
   logic signed [31:0]    mul_res;
   logic                  div_start;
   logic                  div_busy;
   logic [QW-1:0]         div_quo;
   logic [31:0]           div_mag;
   logic [63:0]           quo_wide;
   logic signed [31:0]    div_emass;
   logic                  out_free;

   gcis_mul #(
      .FRAC_BITS(FRAC_BITS)
   ) u_mul (
      .clock(clock),
      .op_a (op_a),
      .op_b (op_b),
      .res  (mul_res)
   );

   gcis_div #(
      .QW(QW)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(DIV_NUM),
      .divisor (div_mag),
      .busy    (div_busy),
      .quotient(div_quo)
   );

   // Magnitude of the inverse mass sum feeds the divider
   assign div_mag = t_ff[31] ? (32'd0 - t_ff) : t_ff;

   // Apply sign to the quotient and clamp to 32 bits
   always_comb begin
      quo_wide = 64'(div_quo);
      if (!neg_ff) begin
         div_emass = (quo_wide > 64'h7fff_ffff) ? S32_MAX : quo_wide[31:0];
      end else begin
         div_emass = (quo_wide > 64'h8000_0000) ? S32_MIN : (32'd0 - quo_wide[31:0]);
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      in_in        = in_ff;
      t_in         = t_ff;
      u_in         = u_ff;
      acc_in       = acc_ff;
      emass_in     = emass_ff;
      bias_in      = bias_ff;
      oa_in        = oa_ff;
      ob_in        = ob_ff;
      tot_in       = tot_ff;
      zero_in      = zero_ff;
      neg_in       = neg_ff;
      op_a         = '0;
      op_b         = '0;
      div_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            // Take a transfer and dispatch on the command
            if (req_valid) begin
               in_in  = req_data;
               oa_in  = req_data.omega_a;
               ob_in  = req_data.omega_b;
               tot_in = acc_ff;
               t_in   = acc_ff;
               case (req_data.command)
                  CMD_PRESOLVE: state_in = ST_PS0;
                  CMD_SOLVE:    state_in = ST_SV0;
                  CMD_APPLY:    state_in = ST_AP0;
                  default:      state_in = ST_FIN;
               endcase
            end
         end
         ST_PS0: begin
            op_a     = opnd_u(in_ff.inv_inertia_a);
            op_b     = opnd_s(rinv_ff);
            state_in = ST_PS1;
         end
         ST_PS1: begin
            t_in     = mul_res;
            op_a     = opnd_u(in_ff.inv_inertia_b);
            op_b     = opnd_s(ratio_ff);
            state_in = ST_PS2;
         end
         ST_PS2: begin
            // Inverse mass sum
            t_in     = sat34(sx34(t_ff) + sx34(mul_res));
            op_a     = opnd_s(in_ff.angle_a);
            op_b     = opnd_s(ratio_ff);
            state_in = ST_PS3;
         end
         ST_PS3: begin
            // Launch the divide; form the position error
            zero_in   = (t_ff == 32'sd0);
            neg_in    = t_ff[31];
            div_start = (t_ff != 32'sd0);
            u_in      = sat34(sx34(mul_res) - sx34(in_ff.angle_b) - sx34(phase_ff));
            state_in  = ST_PS4;
         end
         ST_PS4: begin
            op_a     = opnd_s(u_ff);
            op_b     = BETA_OP;
            state_in = ST_PS5;
         end
         ST_PS5: begin
            u_in     = mul_res;
            state_in = ST_PS6;
         end
         ST_PS6: begin
            op_a     = opnd_s(u_ff);
            op_b     = opnd_u(its_ff);
            state_in = ST_PS7;
         end
         ST_PS7: begin
            bias_in  = mul_res;
            acc_in   = '0;
            tot_in   = '0;
            state_in = ST_PS8;
         end
         ST_PS8: begin
            // Wait for the divider
            if (!div_busy) begin
               emass_in = zero_ff ? 32'sd0 : div_emass;
               state_in = ST_FIN;
            end
         end
         ST_SV0: begin
            op_a     = opnd_s(in_ff.omega_b);
            op_b     = opnd_s(ratio_ff);
            state_in = ST_SV1;
         end
         ST_SV1: begin
            // Velocity error
            t_in     = sat34(sx34(mul_res) - sx34(in_ff.omega_a));
            state_in = ST_SV2;
         end
         ST_SV2: begin
            t_in     = sat34(sx34(bias_ff) - sx34(t_ff));
            state_in = ST_SV3;
         end
         ST_SV3: begin
            op_a     = opnd_s(t_ff);
            op_b     = opnd_s(emass_ff);
            state_in = ST_SV4;
         end
         ST_SV4: begin
            // Accumulate lambda, keep the old total
            u_in     = acc_ff;
            acc_in   = sat34(sx34(acc_ff) + sx34(mul_res));
            state_in = ST_SV5;
         end
         ST_SV5: begin
            t_in     = sat34(sx34(acc_ff) - sx34(u_ff));
            tot_in   = acc_ff;
            state_in = ST_AP0;
         end
         ST_AP0: begin
            op_a     = opnd_s(t_ff);
            op_b     = opnd_u(in_ff.inv_inertia_a);
            state_in = ST_AP1;
         end
         ST_AP1: begin
            u_in     = mul_res;
            op_a     = opnd_s(t_ff);
            op_b     = opnd_u(in_ff.inv_inertia_b);
            state_in = ST_AP2;
         end
         ST_AP2: begin
            ob_in    = sat34(sx34(in_ff.omega_b) + sx34(mul_res));
            op_a     = opnd_s(u_ff);
            op_b     = opnd_s(rinv_ff);
            state_in = ST_AP3;
         end
         ST_AP3: begin
            oa_in    = sat34(sx34(in_ff.omega_a) - sx34(mul_res));
            state_in = ST_FIN;
         end
         ST_FIN: begin
            // Hand the result over once the output register frees
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.omega_a_out   = oa_ff;
               rsp_data_in.omega_b_out   = ob_ff;
               rsp_data_in.impulse_total = tot_ff;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Configuration writes
   always_comb begin
      ratio_in = ratio_ff;
      rinv_in  = rinv_ff;
      phase_in = phase_ff;
      its_in   = its_ff;
      if (csr_we) begin
         case (csr_index)
            REG_GEAR_RATIO:    ratio_in = csr_wdata;
            REG_RATIO_INVERSE: rinv_in  = csr_wdata;
            REG_PHASE_OFFSET:  phase_in = csr_wdata;
            REG_INV_TIMESTEP:  its_in   = csr_wdata[30:0];
            default:           ratio_in = ratio_ff;
         endcase
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
         emass_ff     <= '0;
         bias_ff      <= '0;
         ratio_ff     <= ONE_Q;
         rinv_ff      <= ONE_Q;
         phase_ff     <= '0;
         its_ff       <= ITS_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
         emass_ff     <= emass_in;
         bias_ff      <= bias_in;
         ratio_ff     <= ratio_in;
         rinv_ff      <= rinv_in;
         phase_ff     <= phase_in;
         its_ff       <= its_in;
      end
   end

   // Payload and scratch registers
   always_ff @(posedge clock) begin
      in_ff       <= in_in;
      t_ff        <= t_in;
      u_ff        <= u_in;
      oa_ff       <= oa_in;
      ob_ff       <= ob_in;
      tot_ff      <= tot_in;
      zero_ff     <= zero_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/core/gcis_mul.sv =====
// Shared fixed-point multiplier for the gear solver: registered product,
// then floor shift by the fraction width and saturation. Uses gcis_pkg.
module gcis_mul
   import gcis_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic signed [OPW-1:0] op_a,
   input  logic signed [OPW-1:0] op_b,
   output logic signed [31:0]    res
);

   localparam int PW = 2 * OPW;

   logic signed [PW-1:0] product_ff;
   logic signed [PW-1:0] product_in;
   logic signed [PW-1:0] shifted;

   // Form the exact product
   assign product_in = op_a * op_b;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   // Arithmetic shift rounds toward minus infinity; clamp to 32 bits
   always_comb begin
      shifted = product_ff >>> FRAC_BITS;
      if (&shifted[PW-1:31] || ~|shifted[PW-1:31]) begin
         res = shifted[31:0];
      end else if (shifted[PW-1]) begin
         res = S32_MIN;
      end else begin
         res = S32_MAX;
      end
   end

endmodule

// ===== rtl/core/gcis_div.sv =====
// Restoring divider for the effective mass: one quotient bit per cycle,
// unsigned dividend over a 32-bit unsigned divisor. Uses gcis_pkg.
module gcis_div
   import gcis_pkg::*;
#(
   parameter int QW = 33
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [QW-1:0] dividend,
   input  logic [31:0]   divisor,
   output logic          busy,
   output logic [QW-1:0] quotient
);

   localparam int CW = $clog2(QW + 1);

   logic          busy_ff, busy_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic [31:0]   rem_ff, rem_in;
   logic [31:0]   div_ff, div_in;
   logic [32:0]   shifted;
   logic [32:0]   diff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      shifted = {rem_ff, quo_ff[QW-1]};
      diff    = shifted - {1'b0, div_ff};
      if (start) begin
         // Load dividend; quotient bits shift in behind it
         busy_in = 1'b1;
         cnt_in  = CW'(QW);
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         // Trial subtract and keep the difference when it does not go negative
         if (!diff[32]) begin
            rem_in = diff[31:0];
            quo_in = {quo_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = shifted[31:0];
            quo_in = {quo_ff[QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/core/gcis_checker.sv =====
// Port-level checks for the gear constraint impulse solver, bound to the
// top level. Uses gcis_pkg for the result transfer type.
module gcis_checker
   import gcis_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   // Reset empties the output register
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Block is busy right after taking an item
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken while one is in work");

   // No result appears in the cycle right after a transfer in
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("result appeared without work steps");

endmodule

bind gear_constraint_impulse_solver gcis_checker u_checker (.*);

// ===== dv/tb_top.sv =====
// Self-checking testbench for gear_constraint_impulse_solver: a fixed-point
// predictor of the gear joint solver checks every result transfer in order.
// Depends on gcis_pkg and the solver RTL.
module tb_top;
   import gcis_pkg::*;

   localparam int FRAC = 16;
   localparam longint BETA_Q = ((longint'(1) << FRAC) * 2 + 5) / 10;
   localparam longint Q_MAX = 2147483647;
   localparam longint Q_MIN = -longint'(2147483647) - 1;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int IDLE_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 60;
   localparam int PHASE_ITEMS = 60;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   // Predictor copy of the registers and solver state (reset values)
   longint cfg_ratio = 65536;
   longint cfg_ratio_inv = 65536;
   longint cfg_phase = 0;
   longint cfg_inv_step = 60 * 65536;
   longint acc_impulse = 0;
   longint eff_mass = 0;
   longint vel_bias = 0;

   rsp_type predicted_updates[$];
   int      error_count = 0;
   int      sender_gap_pct = 0;
   int      receiver_stall_pct = 0;
   int      idle_cycles = 0;

   gear_constraint_impulse_solver #(.FRAC_BITS(FRAC)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Randomly hold off the result side
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
   end

   // Clamp to the signed 32-bit range
   function automatic longint clamp32(input longint v);
      if (v > Q_MAX) return Q_MAX;
      if (v < Q_MIN) return Q_MIN;
      return v;
   endfunction

   // Fixed-point product, floor rounding, saturated
   function automatic longint qmul(input longint x, input longint y);
      return clamp32((x * y) >>> FRAC);
   endfunction

   // Advance the predicted solver state by one item and return its result
   function automatic rsp_type solve_gear_item(input req_type r);
      longint ang_a, ang_b, wa, wb, ia, ib, total;
      longint imass, c, cdot, lam, prev, imp;
      rsp_type res;
      ang_a = longint'($signed(r.angle_a));
      ang_b = longint'($signed(r.angle_b));
      wa = longint'($signed(r.omega_a));
      wb = longint'($signed(r.omega_b));
      ia = longint'(r.inv_inertia_a);
      ib = longint'(r.inv_inertia_b);
      total = acc_impulse;
      imp = 0;
      case (r.command)
         CMD_PRESOLVE: begin
            imass = clamp32(qmul(ia, cfg_ratio_inv) + qmul(ib, cfg_ratio));
            if (imass != 0) eff_mass = clamp32((longint'(1) << (2 * FRAC)) / imass);
            else eff_mass = 0;
            c = clamp32(qmul(ang_a, cfg_ratio) - ang_b - cfg_phase);
            vel_bias = qmul(qmul(c, BETA_Q), cfg_inv_step);
            acc_impulse = 0;
            total = 0;
         end
         CMD_SOLVE, CMD_APPLY: begin
            if (r.command == CMD_SOLVE) begin
               cdot = clamp32(qmul(wb, cfg_ratio) - wa);
               lam = qmul(clamp32(vel_bias - cdot), eff_mass);
               prev = acc_impulse;
               acc_impulse = clamp32(acc_impulse + lam);
               imp = clamp32(acc_impulse - prev);
            end else begin
               imp = acc_impulse;
            end
            wa = clamp32(wa - qmul(qmul(imp, ia), cfg_ratio_inv));
            wb = clamp32(wb + qmul(imp, ib));
            total = acc_impulse;
         end
         default: begin
            total = acc_impulse;
         end
      endcase
      res.omega_a_out = wa[31:0];
      res.omega_b_out = wb[31:0];
      res.impulse_total = total[31:0];
      return res;
   endfunction

   task automatic report_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   // Compare each result transfer with the oldest prediction
   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_updates.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual %h", $time, rsp_data);
            error_count++;
         end else begin
            want = predicted_updates.pop_front();
            report_field("omega_a_out", want.omega_a_out, rsp_data.omega_a_out);
            report_field("omega_b_out", want.omega_b_out, rsp_data.omega_b_out);
            report_field("impulse_total", want.impulse_total, rsp_data.impulse_total);
         end
      end
   end

   // End the run when no transfer happens for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("** gear_constraint_impulse_solver: FAILED **");
            $finish;
         end
      end
   end

   // Send one item, hold it until the transfer, then predict its result
   task automatic send_item(input req_type item, output rsp_type predicted);
      while ($urandom_range(0, 99) < sender_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = solve_gear_item(item);
      predicted_updates.push_back(predicted);
   endtask

   // Drop valid and wait for every predicted result
   task automatic finish_phase();
      req_valid <= 1'b0;
      @(posedge clock);
      while (predicted_updates.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [31:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         REG_GEAR_RATIO:    cfg_ratio = longint'($signed(value));
         REG_RATIO_INVERSE: cfg_ratio_inv = longint'($signed(value));
         REG_PHASE_OFFSET:  cfg_phase = longint'($signed(value));
         REG_INV_TIMESTEP:  cfg_inv_step = longint'(value[30:0]);
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic load_config(input logic [31:0] ratio, input logic [31:0] ratio_inv,
                              input logic [31:0] phase, input logic [31:0] inv_step);
      write_csr(REG_GEAR_RATIO, ratio);
      write_csr(REG_RATIO_INVERSE, ratio_inv);
      write_csr(REG_PHASE_OFFSET, phase);
      write_csr(REG_INV_TIMESTEP, inv_step);
      csr_we <= 1'b0;
   endtask

   function automatic req_type make_req(input logic [1:0] cmd,
                                        input logic [31:0] ang_a, input logic [31:0] ang_b,
                                        input logic [31:0] wa, input logic [31:0] wb,
                                        input logic [30:0] ia, input logic [30:0] ib);
      req_type r;
      r.command = cmd;
      r.angle_a = ang_a;
      r.angle_b = ang_b;
      r.omega_a = wa;
      r.omega_b = wb;
      r.inv_inertia_a = ia;
      r.inv_inertia_b = ib;
      return r;
   endfunction

   // Mostly physical magnitudes, some raw bit patterns and limits
   function automatic logic [31:0] pick_value();
      int sel;
      int v;
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
         v = int'($urandom_range(0, 32'h100000)) - 32'h80000;
         return v;
      end
      if (sel < 80) return $urandom;
      case ($urandom_range(0, 4))
         0: return S32_MIN;
         1: return S32_MAX;
         2: return 32'd0;
         3: return 32'hffff_ffff;
         default: return 32'd1;
      endcase
   endfunction

   function automatic logic [30:0] pick_inertia();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 50) return 31'($urandom_range(0, 32'h20000));
      if (sel < 60) return 31'd0;
      if (sel < 85) return 31'($urandom);
      case ($urandom_range(0, 2))
         0: return 31'h7fff_ffff;
         1: return 31'd1;
         default: return 31'h1_0000;
      endcase
   endfunction

   // Pick a register setting: mostly a consistent ratio pair, some extremes
   task automatic load_random_config();
      int sel;
      int ratio;
      logic [31:0] ratio_w, inv_w, step_w;
      longint inv;
      sel = $urandom_range(0, 99);
      ratio = int'($urandom_range(0, 32'h80000)) - 32'h40000;
      if (sel < 10) ratio = 0;
      if (ratio == 0) inv = 0;
      else inv = clamp32((longint'(1) << (2 * FRAC)) / ratio);
      ratio_w = ratio;
      inv_w = inv[31:0];
      if (sel >= 80) begin
         ratio_w = pick_value();
         inv_w = pick_value();
      end
      sel = $urandom_range(0, 99);
      if (sel < 70) step_w = $urandom_range(32'h10_0000, 32'h80_0000);
      else if (sel < 85) step_w = $urandom;
      else if (sel < 92) step_w = 32'd0;
      else step_w = 32'h7fff_ffff;
      load_config(ratio_w, inv_w, pick_value(), step_w);
   endtask

   // Reset register values, solve and apply before any presolve, unused code
   task automatic test_reset_defaults();
      rsp_type p;
      send_item(make_req(CMD_SOLVE, 0, 0, 32'h1_0000, -32'sh8000, 31'h1_0000, 31'h1_0000), p);
      send_item(make_req(CMD_APPLY, 0, 0, 32'h2_0000, 32'h3_0000, 31'h1_0000, 31'h8000), p);
      send_item(make_req(CMD_UNUSED, 32'h1_0000, 0, 32'h1234, -32'sh5678, 31'h1, 31'h2), p);
      send_item(make_req(CMD_PRESOLVE, 32'h1_8000, 32'h1_0000, 0, 0, 31'h1_0000, 31'h8000), p);
      send_item(make_req(CMD_SOLVE, 0, 0, 32'h4000, -32'sh4000, 31'h1_0000, 31'h8000), p);
      send_item(make_req(CMD_SOLVE, 0, 0, p.omega_a_out, p.omega_b_out,
                         31'h1_0000, 31'h8000), p);
      send_item(make_req(CMD_APPLY, 0, 0, 0, 0, 31'h1_0000, 31'h8000), p);
      finish_phase();
   endtask

   // Register and field extremes, zero ratio, zero inverse mass sum, saturation
   task automatic test_corner_cases();
      rsp_type p;
      load_config(S32_MAX, S32_MIN, S32_MIN, 32'h7fff_ffff);
      send_item(make_req(CMD_PRESOLVE, S32_MIN, S32_MAX, 0, 0, 31'h7fff_ffff,
                         31'h7fff_ffff), p);
      send_item(make_req(CMD_SOLVE, 0, 0, S32_MAX, S32_MIN, 31'h7fff_ffff, 31'h7fff_ffff), p);
      send_item(make_req(CMD_APPLY, 0, 0, S32_MIN, S32_MAX, 31'h7fff_ffff, 31'h7fff_ffff), p);
      send_item(make_req(CMD_UNUSED, S32_MAX, S32_MIN, S32_MAX, S32_MIN, 31'h7fff_ffff,
                         31'h7fff_ffff), p);
      finish_phase();

      // Zero ratio: the inverse is used as written
      load_config(32'd0, 32'd0, S32_MAX, 32'd0);
      send_item(make_req(CMD_PRESOLVE, 32'h1_0000, S32_MIN, 0, 0, 31'h1_0000, 31'h1_0000), p);
      send_item(make_req(CMD_SOLVE, 0, 0, 32'h1_0000, S32_MAX, 31'h1_0000, 31'h1_0000), p);
      send_item(make_req(CMD_APPLY, 0, 0, 32'h1_0000, 32'h1_0000, 31'h1_0000, 31'h1_0000), p);
      finish_phase();

      // Zero inverse mass sum
      load_config(S32_MIN, S32_MAX, 32'd0, 32'd1);
      send_item(make_req(CMD_PRESOLVE, S32_MAX, 0, 0, 0, 31'd0, 31'd0), p);
      send_item(make_req(CMD_SOLVE, 0, 0, S32_MIN, S32_MAX, 31'd0, 31'd0), p);
      finish_phase();

      // Negative ratio, accumulation driven into saturation
      load_config(32'hffff_0000, 32'hffff_0000, 32'h3_0000, 32'h3c_0000);
      send_item(make_req(CMD_PRESOLVE, 32'h7000_0000, S32_MIN, 0, 0, 31'h1, 31'h1), p);
      send_item(make_req(CMD_SOLVE, 0, 0, S32_MIN, S32_MIN, 31'h7fff_ffff, 31'h1), p);
      send_item(make_req(CMD_SOLVE, 0, 0, S32_MAX, S32_MAX, 31'h1, 31'h7fff_ffff), p);
      send_item(make_req(CMD_SOLVE, 0, 0, p.omega_a_out, p.omega_b_out, 31'h1, 31'h1), p);
      send_item(make_req(CMD_APPLY, 0, 0, S32_MAX, S32_MIN, 31'h7fff_ffff,
                         31'h7fff_ffff), p);
      finish_phase();
   endtask

   // Presolve / solve / apply sequences with random content, plus noise
   task automatic test_random_sequences(input int gap_pct, input int stall_pct,
                                        input int item_count);
      int sent;
      int phase_sent;
      int n_solve;
      logic [31:0] ang_a, ang_b, wa, wb;
      logic [30:0] ia, ib;
      req_type item;
      rsp_type p;
      sender_gap_pct = gap_pct;
      receiver_stall_pct = stall_pct;
      sent = 0;
      while (sent < item_count) begin
         load_random_config();
         phase_sent = 0;
         while (phase_sent < PHASE_ITEMS) begin
            ang_a = pick_value();
            ang_b = pick_value();
            wa = pick_value();
            wb = pick_value();
            ia = pick_inertia();
            ib = pick_inertia();
            if ($urandom_range(0, 9) == 0) begin
               // Stray item with any code, breaks the sequence
               item = make_req(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                               $urandom, 31'($urandom), 31'($urandom));
               send_item(item, p);
               phase_sent++;
            end else begin
               send_item(make_req(CMD_PRESOLVE, ang_a, ang_b, wa, wb, ia, ib), p);
               phase_sent++;
               n_solve = $urandom_range(1, 8);
               repeat (n_solve) begin
                  // Feed the updated velocities back most of the time
                  if ($urandom_range(0, 9) < 7) begin
                     wa = p.omega_a_out;
                     wb = p.omega_b_out;
                  end else begin
                     wa = pick_value();
                     wb = pick_value();
                  end
                  send_item(make_req(CMD_SOLVE, ang_a, ang_b, wa, wb, ia, ib), p);
                  phase_sent++;
               end
               if ($urandom_range(0, 1) == 1) begin
                  send_item(make_req(CMD_APPLY, ang_a, ang_b, pick_value(), pick_value(),
                                     ia, ib), p);
                  phase_sent++;
               end
            end
         end
         finish_phase();
         sent += phase_sent;
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      sender_gap_pct = 10;
      receiver_stall_pct = 81;
      test_reset_defaults();
      test_corner_cases();
      test_random_sequences(10, 81, 300);
      test_random_sequences(81, 10, 300);
      test_random_sequences(0, 0, 300);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("** gear_constraint_impulse_solver: PASSED **");
      end else begin
         $display("** gear_constraint_impulse_solver: FAILED **");
      end
      $finish;
   end

endmodule
